[src/gbpe_pkg.sv]
package gbpe_pkg;

   // Width of the internal cursor arithmetic; coordinates wrap modulo 2**COORD_WIDTH.
   localparam int COORD_WIDTH = 10;

   // Fixed widths of the port fields.
   localparam int PIXEL_COORD_WIDTH = 10;
   localparam int COLOR_WIDTH       = 16;
   localparam int HEIGHT_WIDTH      = 7;
   localparam int BYTE_WIDTH        = 8;

   typedef logic [COORD_WIDTH-1:0]       coord_type;
   typedef logic [PIXEL_COORD_WIDTH-1:0] pixel_coord_type;
   typedef logic [COLOR_WIDTH-1:0]       color_type;

   // One accepted byte as handed to the pixel emitter.
   typedef struct packed {
      coord_type             x;
      coord_type             y0;
      logic [BYTE_WIDTH-1:0] bits;
      logic [BYTE_WIDTH-1:0] emit;
   } work_type;

   // Bits that are examined before the column break, top bit first.
   // When the break falls inside the byte, last_idx is the offset of the
   // final examined bit.
   function automatic logic [BYTE_WIDTH-1:0] examine_mask(input logic brk,
                                                          input logic [2:0] last_idx);
      logic [BYTE_WIDTH-1:0] m;
      m = '1;
      if (brk) begin
         m = 8'hFF << (3'd7 - last_idx);
      end
      return m;
   endfunction

endpackage

[src/gbpe_emit.sv]
module gbpe_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_valid,
   output logic                     load_ready,
   input  gbpe_pkg::work_type       load_work,
   input  gbpe_pkg::color_type      fore_color,
   input  gbpe_pkg::color_type      bg_color,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output gbpe_pkg::pixel_coord_type rsp_pixel_x,
   output gbpe_pkg::pixel_coord_type rsp_pixel_y,
   output gbpe_pkg::color_type      rsp_pixel_color,
   output logic                     rsp_last
);
   import gbpe_pkg::*;

   // Work register: the byte being expanded. emit_ff doubles as its valid flag.
   coord_type             x_ff;
   coord_type             y0_ff;
   logic [BYTE_WIDTH-1:0] bits_ff;
   logic [BYTE_WIDTH-1:0] emit_ff, emit_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   pixel_coord_type pixel_x_ff, pixel_y_ff;
   color_type       pixel_color_ff;
   logic            last_ff;

   logic [2:0]            idx;
   logic [BYTE_WIDTH-1:0] emit_rest;
   logic                  out_free;
   logic                  step;
   logic                  load;

   // Pick the topmost pixel still to be written.
   always_comb begin
      idx = '0;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if (emit_ff[i]) begin
            idx = 3'(i);
         end
      end
   end

   assign emit_rest  = emit_ff & ~(8'h01 << idx);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign step       = (emit_ff != '0) && out_free;
   assign load_ready = (emit_ff == '0) || (step && (emit_rest == '0));
   assign load       = load_valid && load_ready;

   always_comb begin
      emit_in = emit_ff;
      if (load) begin
         emit_in = load_work.emit;
      end else if (step) begin
         emit_in = emit_rest;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Work payload is captured on each input transfer.
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= load_work.x;
         y0_ff   <= load_work.y0;
         bits_ff <= load_work.bits;
      end
   end

   // Result payload; bit 7 is the top row, so its row offset is 7 - idx.
   always_ff @(posedge clock) begin
      if (step) begin
         pixel_x_ff     <= PIXEL_COORD_WIDTH'(x_ff);
         pixel_y_ff     <= PIXEL_COORD_WIDTH'(y0_ff + COORD_WIDTH'(3'd7 - idx));
         pixel_color_ff <= bits_ff[idx] ? fore_color : bg_color;
         last_ff        <= (emit_rest == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_last        = last_ff;

endmodule

[src/glyph_bitmap_pixel_expander_core.sv]
// Glyph bitmap pixel expander.
// Input channel (req_*): one bitmap byte per transfer, eight vertical pixels with
// the most significant bit on top. req_new_glyph loads the cursor and top row
// from req_start_x / req_start_y before the byte is expanded.
// Result channel (rsp_*): one pixel write per transfer; rsp_last marks the final
// write caused by a byte. A byte with no writes (transparent mode, all examined
// bits clear) produces no transfer at all.
// Configuration channel (csr_*): register writes, always ready; index 0 is the
// foreground color, 1 the background color, 2 the transparent flag and 3 the
// glyph height. Write only while the block is idle.
// A byte is captured in the emitter's work register at its transfer; each of its
// pixels then passes into the result register, from which it is offered.
// One pixel per cycle while the receiver keeps taking results; a byte with N
// pixel writes (up to 8) is issued one pixel at a time through the pixel
// emitter's single result register. The next byte is taken in the cycle that
// issues the last pixel of the current one.
// A stalled receiver holds the result register; the emitter then stops and
// req_ready falls once a byte is waiting. Reset clears the cursor, the top row
// and both pipeline registers and restores the register defaults.
module glyph_bitmap_pixel_expander_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_new_glyph,
   input  gbpe_pkg::pixel_coord_type req_start_x,
   input  gbpe_pkg::pixel_coord_type req_start_y,
   input  logic [7:0]                req_bitmap_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output gbpe_pkg::pixel_coord_type rsp_pixel_x,
   output gbpe_pkg::pixel_coord_type rsp_pixel_y,
   output gbpe_pkg::color_type       rsp_pixel_color,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_data
);
   import gbpe_pkg::*;

   localparam logic [1:0] REG_FORE_COLOR   = 2'd0;
   localparam logic [1:0] REG_BG_COLOR     = 2'd1;
   localparam logic [1:0] REG_TRANSPARENT  = 2'd2;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

   color_type               fore_color_ff, bg_color_ff;
   logic                    transparent_ff;
   logic [HEIGHT_WIDTH-1:0] glyph_height_ff;

   coord_type cursor_x_ff, cursor_x_in;
   coord_type cursor_y_ff, cursor_y_in;
   coord_type top_row_ff, top_row_in;

   coord_type eff_x, eff_y, eff_top;
   coord_type offset, rows_left;
   logic      brk;
   logic      accept;
   work_type  work;
   logic      emit_ready;

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fore_color_ff   <= 16'h0000;
         bg_color_ff     <= 16'hFFFF;
         transparent_ff  <= 1'b0;
         glyph_height_ff <= 7'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FORE_COLOR:   fore_color_ff   <= csr_data;
            REG_BG_COLOR:     bg_color_ff     <= csr_data;
            REG_TRANSPARENT:  transparent_ff  <= csr_data[0];
            REG_GLYPH_HEIGHT: glyph_height_ff <= csr_data[HEIGHT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Cursor as seen by this byte, after an optional glyph start.
   always_comb begin
      eff_x   = cursor_x_ff;
      eff_y   = cursor_y_ff;
      eff_top = top_row_ff;
      if (req_new_glyph) begin
         eff_x   = COORD_WIDTH'(req_start_x);
         eff_y   = COORD_WIDTH'(req_start_y);
         eff_top = COORD_WIDTH'(req_start_y);
      end
   end

   // Rows left in the column minus one; the break lands inside this byte
   // when that count is below eight.
   assign offset    = eff_y - eff_top;
   assign rows_left = COORD_WIDTH'(glyph_height_ff) - offset - COORD_WIDTH'(1);
   assign brk       = (rows_left >> 3) == '0;

   always_comb begin
      work.x    = eff_x;
      work.y0   = eff_y;
      work.bits = req_bitmap_byte;
      work.emit = examine_mask(brk, rows_left[2:0])
                  & (req_bitmap_byte | {BYTE_WIDTH{~transparent_ff}});
   end

   assign accept    = req_valid && emit_ready;
   assign req_ready = emit_ready;

   // The cursor advances for the whole byte at its transfer.
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      top_row_in  = top_row_ff;
      if (accept) begin
         top_row_in = eff_top;
         if (brk) begin
            cursor_x_in = eff_x + COORD_WIDTH'(1);
            cursor_y_in = eff_top;
         end else begin
            cursor_x_in = eff_x;
            cursor_y_in = eff_y + COORD_WIDTH'(8);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         top_row_ff  <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         top_row_ff  <= top_row_in;
      end
   end

   gbpe_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (req_valid),
      .load_ready      (emit_ready),
      .load_work       (work),
      .fore_color      (fore_color_ff),
      .bg_color        (bg_color_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

[src/gbpe_checker.sv]
module gbpe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input gbpe_pkg::pixel_coord_type rsp_pixel_x,
   input logic                      rsp_last
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A byte's pixels follow each other without gaps.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside the pixels of one byte");

   // All pixels of one byte lie in the same column.
   a_same_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_pixel_x == $past(rsp_pixel_x))
      else $error("column changed inside one byte");

endmodule

bind glyph_bitmap_pixel_expander_core gbpe_checker u_checker (.*);

[verif/pixel_write_checker.sv]
`timescale 1ns / 1ps

// Register map of the configuration channel, shared by the stimulus and the checker.
package glyph_csr_pkg;

   typedef enum logic [1:0] {
      CSR_FORE_COLOR   = 2'd0,
      CSR_BG_COLOR     = 2'd1,
      CSR_TRANSPARENT  = 2'd2,
      CSR_GLYPH_HEIGHT = 2'd3
   } csr_index_type;

endpackage

module pixel_write_checker
   import gbpe_pkg::*;
   import glyph_csr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  logic            req_new_glyph,
   input  pixel_coord_type req_start_x,
   input  pixel_coord_type req_start_y,
   input  logic [7:0]      req_bitmap_byte,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  pixel_coord_type rsp_pixel_x,
   input  pixel_coord_type rsp_pixel_y,
   input  color_type       rsp_pixel_color,
   input  logic            rsp_last,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data,
   output int              mismatch_count,
   output logic            drained
);

   typedef struct {
      pixel_coord_type x;
      pixel_coord_type y;
      color_type       color;
      logic            last;
   } pixel_write_type;

   // Shadow copy of the configuration registers.
   color_type                fore_color;
   color_type                bg_color;
   logic                     transparent;
   logic [HEIGHT_WIDTH-1:0]  glyph_height;

   // Shadow copy of the drawing cursor.
   coord_type cursor_x;
   coord_type cursor_y;
   coord_type top_row;

   pixel_write_type expected_pixels[$];
   int              failures = 0;

   assign mismatch_count = failures;

   // Expand one accepted bitmap byte into the pixel writes it must cause.
   task automatic expand_bitmap_byte(input logic new_glyph, input pixel_coord_type start_x,
                                     input pixel_coord_type start_y, input logic [7:0] bitmap);
      pixel_write_type writes[8];
      int              count;
      logic [7:0]      bits;
      logic            lit;
      coord_type       row_offset;
      count = 0;
      bits  = bitmap;
      if (new_glyph) begin
         cursor_x = coord_type'(start_x);
         cursor_y = coord_type'(start_y);
         top_row  = cursor_y;
      end
      for (int row = 0; row < 8; row++) begin
         lit = bits[7];
         if (lit || !transparent) begin
            writes[count] = '{x: pixel_coord_type'(cursor_x), y: pixel_coord_type'(cursor_y),
                              color: lit ? fore_color : bg_color, last: 1'b0};
            count++;
         end
         bits       = bits << 1;
         cursor_y   = cursor_y + 1'b1;
         row_offset = cursor_y - top_row;
         // The column ends once the cursor is a full glyph height below the top row.
         if (32'(row_offset) == 32'(glyph_height)) begin
            cursor_y = top_row;
            cursor_x = cursor_x + 1'b1;
            break;
         end
      end
      if (count > 0) begin
         writes[count - 1].last = 1'b1;
      end
      for (int n = 0; n < count; n++) begin
         expected_pixels.push_back(writes[n]);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_write_type got;
      pixel_write_type want;
      if (reset) begin
         fore_color   = '0;
         bg_color     = '1;
         transparent  = 1'b0;
         glyph_height = 7'd16;
         cursor_x     = '0;
         cursor_y     = '0;
         top_row      = '0;
         expected_pixels.delete();
         drained <= 1'b1;
      end else begin
         // Register writes update the shadow configuration.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FORE_COLOR:   fore_color   = csr_data;
               CSR_BG_COLOR:     bg_color     = csr_data;
               CSR_TRANSPARENT:  transparent  = csr_data[0];
               CSR_GLYPH_HEIGHT: glyph_height = csr_data[HEIGHT_WIDTH-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            expand_bitmap_byte(req_new_glyph, req_start_x, req_start_y, req_bitmap_byte);
         end

         // Each result transfer is compared against the oldest expected pixel write.
         if (rsp_valid && rsp_ready) begin
            got = '{x: rsp_pixel_x, y: rsp_pixel_y, color: rsp_pixel_color, last: rsp_last};
            if (expected_pixels.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("unexpected pixel write: x=%0d y=%0d color=%h last=%b",
                           got.x, got.y, got.color, got.last);
               end
            end else begin
               want = expected_pixels.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                   got.last !== want.last) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("pixel write mismatch: expected x=%0d y=%0d color=%h last=%b",
                              want.x, want.y, want.color, want.last);
                     $display("                      actual   x=%0d y=%0d color=%h last=%b",
                              got.x, got.y, got.color, got.last);
                  end
               end
            end
         end

         drained <= (expected_pixels.size() == 0);
      end
   end

endmodule

[verif/glyph_bitmap_pixel_expander_core_test.sv]
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander_core_test;
   import gbpe_pkg::*;
   import glyph_csr_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 32;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic            req_new_glyph;
   pixel_coord_type req_start_x;
   pixel_coord_type req_start_y;
   logic [7:0]      req_bitmap_byte;
   logic            rsp_valid;
   logic            rsp_ready;
   pixel_coord_type rsp_pixel_x;
   pixel_coord_type rsp_pixel_y;
   color_type       rsp_pixel_color;
   logic            rsp_last;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [15:0]     csr_data;
   int              mismatch_count;
   logic            drained;

   int cycle_count    = 0;
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;

   glyph_bitmap_pixel_expander_core DUT (.*);

   pixel_write_checker pixel_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Random receiver back-pressure, plus the watchdog on the run length.
   always @(posedge clock) begin
      rsp_ready   <= ($urandom_range(0, 99) >= recv_stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
         IDLE_SENDER:   begin send_gap_pct = 84; recv_stall_pct <= 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct <= 84; end
         default:       begin send_gap_pct = 9;  recv_stall_pct <= 9;  end
      endcase
   endtask

   // One byte transfer on the input channel; returns at the accepting edge.
   task automatic send_byte(input logic new_glyph, input pixel_coord_type start_x,
                            input pixel_coord_type start_y, input logic [7:0] bitmap);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_new_glyph   <= new_glyph;
      req_start_x     <= start_x;
      req_start_y     <= start_y;
      req_bitmap_byte <= bitmap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Narrow registers get random upper bits, which the block must ignore.
   task automatic configure(input color_type fore, input color_type back,
                            input logic transparent, input logic [6:0] height);
      logic [15:0] junk;
      junk = $urandom;
      write_register(CSR_FORE_COLOR, fore);
      write_register(CSR_BG_COLOR, back);
      write_register(CSR_TRANSPARENT, {junk[15:1], transparent});
      write_register(CSR_GLYPH_HEIGHT, {junk[15:7], height});
      csr_valid <= 1'b0;
   endtask

   // Stop sending and let every outstanding pixel write drain out of the block.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!drained) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pixel_coord_type pick_coord();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return pixel_coord_type'(1023 - $urandom_range(0, 70));
         default: return pixel_coord_type'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [7:0] pick_bitmap();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80 >> $urandom_range(0, 7);
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int   sent;
      int   run_len;
      logic new_glyph;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_new_glyph   = 1'b0;
      req_start_x     = '0;
      req_start_y     = '0;
      req_bitmap_byte = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Opaque glyphs: full column, column break mid-stream, wrap at the far corner.
      set_idle_mode(IDLE_NONE);
      configure(16'hF800, 16'h001F, 1'b0, 7'd16);
      send_byte(1'b1, 10'd0, 10'd0, 8'h80);
      send_byte(1'b0, 10'd0, 10'd0, 8'hFF);
      send_byte(1'b0, 10'd0, 10'd0, 8'h00);
      send_byte(1'b0, 10'd0, 10'd0, 8'h55);
      send_byte(1'b1, 10'd1023, 10'd1023, 8'hA5);
      send_byte(1'b0, 10'd0, 10'd0, 8'h3C);
      send_byte(1'b1, 10'd512, 10'd1016, 8'hFF);
      wait_until_drained();

      // Transparent mode with a short column: bytes that cause no writes at all.
      configure(16'h07E0, 16'hFFFF, 1'b1, 7'd3);
      send_byte(1'b1, 10'd1023, 10'd1022, 8'h00);
      send_byte(1'b0, 10'd0, 10'd0, 8'hE0);
      send_byte(1'b0, 10'd1023, 10'd1023, 8'h1F);
      send_byte(1'b0, 10'd0, 10'd0, 8'h80);
      send_byte(1'b1, 10'd10, 10'd20, 8'h01);
      wait_until_drained();

      // One-row glyphs break after the first bit of every byte.
      configure(16'hFFFF, 16'h0000, 1'b0, 7'd1);
      send_byte(1'b1, 10'd0, 10'd1023, 8'hFF);
      send_byte(1'b0, 10'd0, 10'd0, 8'h00);
      wait_until_drained();

      // A zero height never breaks until the row offset wraps around.
      configure(16'h1234, 16'hABCD, 1'b0, 7'd0);
      send_byte(1'b1, 10'd100, 10'd1000, 8'hFF);
      send_byte(1'b0, 10'd0, 10'd0, 8'h0F);
      send_byte(1'b0, 10'd0, 10'd0, 8'hAA);
      wait_until_drained();

      // Random glyph runs over a range of settings and idle patterns.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               set_idle_mode(IDLE_NONE);
               configure(16'($urandom), 16'($urandom), 1'b0, 7'($urandom_range(1, 64)));
            end
            1: begin
               set_idle_mode(IDLE_SENDER);
               configure(16'($urandom), 16'($urandom), 1'b1, 7'd64);
            end
            2: begin
               set_idle_mode(IDLE_RECEIVER);
               configure(16'h0000, 16'hFFFF, 1'b0, 7'd1);
            end
            3: begin
               set_idle_mode(IDLE_BOTH);
               configure(16'($urandom), 16'($urandom), 1'b1, 7'd8);
            end
            4: begin
               set_idle_mode(IDLE_RECEIVER);
               configure(16'($urandom), 16'($urandom), 1'b0, 7'd127);
            end
            5: begin
               set_idle_mode(IDLE_SENDER);
               configure(16'($urandom), 16'($urandom), 1'b1, 7'd0);
            end
            6: begin
               set_idle_mode(IDLE_BOTH);
               configure(16'($urandom), 16'($urandom), 1'b0, 7'($urandom_range(1, 64)));
            end
            default: begin
               set_idle_mode(IDLE_NONE);
               configure(16'hFFFF, 16'h0000, 1'b0, 7'd64);
            end
         endcase

         // Most runs start a new glyph; some carry on from where the last one stopped.
         sent = 0;
         while (sent < PHASE_BYTES) begin
            run_len = $urandom_range(1, 10);
            for (int k = 0; k < run_len && sent < PHASE_BYTES; k++) begin
               new_glyph = (k == 0) && ($urandom_range(0, 5) != 0);
               if (new_glyph) begin
                  send_byte(1'b1, pick_coord(), pick_coord(), pick_bitmap());
               end else begin
                  send_byte(1'b0, pixel_coord_type'($urandom_range(0, 1023)),
                            pixel_coord_type'($urandom_range(0, 1023)), pick_bitmap());
               end
               sent++;
            end
         end
         wait_until_drained();
      end

      if (mismatch_count == 0 && drained) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
src/gbpe_pkg.sv
src/gbpe_emit.sv
src/glyph_bitmap_pixel_expander_core.sv
src/gbpe_checker.sv
verif/pixel_write_checker.sv
verif/glyph_bitmap_pixel_expander_core_test.sv
